// ----- hw/rtl/abn_pkg.sv -----
// ----------------------------------------------------------------------------
// abn_pkg: shared types, constants and microcode for the abundance test
// Widths, control word layout, the microprogram table and small helpers
// used by the sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
package abn_pkg;

    // Value width used for n; port width of n and divisor_sum are fixed
    localparam int VALUE_BITS   = 16;
    localparam int IN_N_BITS    = 16;
    localparam int OUT_SUM_BITS = 20;
    // Proper divisor sum stays below 5*n for any n under 2^32
    localparam int SUM_BITS     = VALUE_BITS + 3;
    localparam int CMP_BITS     = (SUM_BITS > OUT_SUM_BITS) ? SUM_BITS : OUT_SUM_BITS;
    localparam int EXT_BITS     = (IN_N_BITS > VALUE_BITS) ? IN_N_BITS : VALUE_BITS;

    typedef logic [VALUE_BITS-1:0]        t_val;
    typedef logic signed [VALUE_BITS:0]   t_rem;
    typedef logic [SUM_BITS-1:0]          t_sum;
    typedef logic [IN_N_BITS-1:0]         t_in_n;
    typedef logic [OUT_SUM_BITS-1:0]      t_out_sum;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_TSTEP,
        OP_FIX,
        OP_EMIT
    } t_op;

    // Branch conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_HALF_ZERO,
        COND_AT_HALF,
        COND_R_NEG,
        COND_OUT_FREE
    } t_cond;

    // Microprogram addresses
    typedef logic [2:0] t_upc;
    localparam t_upc UPC_IDLE  = 3'd0;
    localparam t_upc UPC_CHECK = 3'd1;
    localparam t_upc UPC_TSTEP = 3'd2;
    localparam t_upc UPC_FIX   = 3'd3;
    localparam t_upc UPC_EMIT  = 3'd4;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  tgt_true;
        t_upc  tgt_false;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic hit;
    } t_dp_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic half_zero;
        logic at_half;
        logic r_neg;
        logic out_free;
    } t_dp_stat;

    // Microprogram: trial divisor walk with an incremental quotient/remainder
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        case (pc)
            UPC_IDLE:  w = '{OP_LOAD,  COND_IN_VALID,  UPC_CHECK, UPC_IDLE};
            UPC_CHECK: w = '{OP_NONE,  COND_HALF_ZERO, UPC_EMIT,  UPC_TSTEP};
            UPC_TSTEP: w = '{OP_TSTEP, COND_AT_HALF,   UPC_EMIT,  UPC_FIX};
            UPC_FIX:   w = '{OP_FIX,   COND_R_NEG,     UPC_FIX,   UPC_TSTEP};
            UPC_EMIT:  w = '{OP_EMIT,  COND_OUT_FREE,  UPC_IDLE,  UPC_EMIT};
            default:   w = '{OP_NONE,  COND_ALWAYS,    UPC_IDLE,  UPC_IDLE};
        endcase
        return w;
    endfunction

    // Keep the low VALUE_BITS of the input, zero-extend when wider
    function automatic t_val take_value(input t_in_n n);
        logic [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(n);
        return ext[VALUE_BITS-1:0];
    endfunction

    // Clamp the exact sum to the output width
    function automatic t_out_sum sat_sum(input t_sum total);
        logic [CMP_BITS-1:0] ext;
        ext = CMP_BITS'(total);
        if (ext > CMP_BITS'({OUT_SUM_BITS{1'b1}})) begin
            return '1;
        end
        return ext[OUT_SUM_BITS-1:0];
    endfunction

endpackage

// ----- hw/rtl/abn_if.sv -----
// ----------------------------------------------------------------------------
// abn_if: valid/ready channels of the abundance test
// Input channel carries n, output channel carries the sum and the flag.
// ----------------------------------------------------------------------------
interface abn_in_if;
    import abn_pkg::*;
    logic  valid;
    logic  ready;
    t_in_n n;

    modport source (output valid, output n, input ready);
    modport sink   (input valid, input n, output ready);
endinterface

interface abn_out_if;
    import abn_pkg::*;
    logic     valid;
    logic     ready;
    t_out_sum divisor_sum;
    logic     is_abundant;

    modport source (output valid, output divisor_sum, output is_abundant, input ready);
    modport sink   (input valid, input divisor_sum, input is_abundant, output ready);
endinterface

// ----- hw/rtl/abn_useq.sv -----
// ----------------------------------------------------------------------------
// abn_useq: microcode sequencer
// Step counter over the microprogram table; each word picks a datapath
// operation, a branch condition and the two successor steps.
// ----------------------------------------------------------------------------
module abn_useq
    import abn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl,
    output logic     o_in_ready
);

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword w_word;
    logic   w_hit;

    // Fetch
    assign w_word = ucode_rom(r_pc);

    // Branch condition select
    always_comb begin
        case (w_word.cond)
            COND_ALWAYS:    w_hit = 1'b1;
            COND_IN_VALID:  w_hit = i_in_valid;
            COND_HALF_ZERO: w_hit = i_stat.half_zero;
            COND_AT_HALF:   w_hit = i_stat.at_half;
            COND_R_NEG:     w_hit = i_stat.r_neg;
            COND_OUT_FREE:  w_hit = i_stat.out_free;
            default:        w_hit = 1'b0;
        endcase
    end

    assign n_pc       = w_hit ? w_word.tgt_true : w_word.tgt_false;
    assign o_ctrl     = '{op: w_word.op, hit: w_hit};
    assign o_in_ready = (r_pc == UPC_IDLE);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UPC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // A beat is taken only from the idle step, and it always starts the check
    a_load_goes_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_pc == UPC_CHECK))
        else $error("accepted beat did not start the check step");

    // The fix loop only repeats while the remainder is negative
    a_fix_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == UPC_FIX && !i_stat.r_neg) |=> (r_pc == UPC_TSTEP))
        else $error("fix step did not return to trial step");

    // Emit waits in place until the output register is free
    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == UPC_EMIT && !i_stat.out_free) |=> (r_pc == UPC_EMIT))
        else $error("emit step left while output register busy");

endmodule

// ----- hw/rtl/abn_dpath.sv -----
// ----------------------------------------------------------------------------
// abn_dpath: trial divisor datapath and output register
// Keeps n = q*d + r while d counts up; a zero remainder adds d to the
// running total. Result goes to an output register held until taken.
// ----------------------------------------------------------------------------
module abn_dpath
    import abn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_ctrl i_ctrl,
    input  t_in_n    i_n,
    input  logic     i_out_ready,
    output t_dp_stat o_stat,
    output logic     o_out_valid,
    output t_out_sum o_divisor_sum,
    output logic     o_is_abundant
);

    t_val     r_n, n_n;
    t_val     r_half, n_half;
    t_val     r_d, n_d;
    t_val     r_q, n_q;
    t_rem     r_r, n_r;
    t_sum     r_total, n_total;
    logic     r_out_valid, n_out_valid;
    t_out_sum r_out_sum, n_out_sum;
    logic     r_out_abund, n_out_abund;
    t_val     w_n_eff;
    logic     w_out_free;

    assign w_n_eff    = take_value(i_n);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Status for the sequencer
    assign o_stat = '{half_zero: (r_half == '0),
                      at_half:   (r_d == r_half),
                      r_neg:     r_r[VALUE_BITS],
                      out_free:  w_out_free};

    // Next values per operation
    always_comb begin
        n_n         = r_n;
        n_half      = r_half;
        n_d         = r_d;
        n_q         = r_q;
        n_r         = r_r;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_sum   = r_out_sum;
        n_out_abund = r_out_abund;
        case (i_ctrl.op)
            OP_LOAD: begin
                if (i_ctrl.hit) begin
                    n_n     = w_n_eff;
                    n_half  = w_n_eff >> 1;
                    n_d     = VALUE_BITS'(1);
                    n_q     = w_n_eff;
                    n_r     = '0;
                    n_total = '0;
                end
            end
            OP_TSTEP: begin
                // remainder zero: d divides n
                if (r_r == '0) begin
                    n_total = r_total + SUM_BITS'(r_d);
                end
                n_d = r_d + VALUE_BITS'(1);
                n_r = r_r - $signed({1'b0, r_q});
            end
            OP_FIX: begin
                // pull the remainder back into range, one quotient step
                if (i_ctrl.hit) begin
                    n_r = r_r + $signed({1'b0, r_d});
                    n_q = r_q - VALUE_BITS'(1);
                end
            end
            OP_EMIT: begin
                if (i_ctrl.hit) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = sat_sum(r_total);
                    n_out_abund = (r_total > SUM_BITS'(r_n));
                end
            end
            default: begin
            end
        endcase
    end

    // Working registers and output payload
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_half      <= n_half;
        r_d         <= n_d;
        r_q         <= n_q;
        r_r         <= n_r;
        r_total     <= n_total;
        r_out_sum   <= n_out_sum;
        r_out_abund <= n_out_abund;
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_divisor_sum = r_out_sum;
    assign o_is_abundant = r_out_abund;

    // Remainder is in [0, d) whenever a trial divisor is tested
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_TSTEP) |-> (!r_r[VALUE_BITS] && (r_r < $signed({1'b0, r_d}))))
        else $error("remainder out of range at trial step");

    // Trial divisor never passes n/2
    a_d_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_TSTEP) |-> (r_d <= r_half) && (r_d != '0))
        else $error("trial divisor out of range");

    // A granted emit always raises output valid
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_EMIT && i_ctrl.hit) |=> r_out_valid)
        else $error("emit did not load the output register");

endmodule

// ----- hw/rtl/abundant_number_test.sv -----
// ----------------------------------------------------------------------------
// abundant_number_test: aliquot sum and abundance flag of n
// Top level: microcode sequencer, trial divisor datapath, channel wiring.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  (sink)  : one beat carries n; taken when valid and ready are high.
//   o_out (source): one beat per input, divisor_sum (clamped to 20 bits)
//                   and is_abundant (sum greater than n).
//   One item at a time. An item of n runs a check step, then a trial step
//   for each divisor from 1 to n/2, each trial but the last followed by its
//   quotient-fix steps and a fix-loop exit step, then an emit step; for
//   n = 0 or 1 the check step goes straight to the emit step. The trial/fix
//   loop on the single remainder register sets the run time of an item.
//   The result sits in an output register; ready goes high again in the
//   same cycle as output valid, so the next n is taken while the result
//   waits. If the receiver stalls, the next result waits in the emit step
//   until the output register frees, and no further beat is taken
//   meanwhile.
//   Reset (synchronous, active low) returns the sequencer to idle and
//   drops output valid; nothing is kept between items.
// ----------------------------------------------------------------------------
module abundant_number_test
    import abn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    abn_in_if.sink    i_in,
    abn_out_if.source o_out
);

    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;
    logic     w_in_ready;

    // Sequencer
    abn_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_in_ready (w_in_ready)
    );

    // Datapath
    abn_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_n           (i_in.n),
        .i_out_ready   (o_out.ready),
        .o_stat        (w_stat),
        .o_out_valid   (o_out.valid),
        .o_divisor_sum (o_out.divisor_sum),
        .o_is_abundant (o_out.is_abundant)
    );

    assign i_in.ready = w_in_ready;

endmodule

// ----- test/abundant_number_test_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// abundant_number_test_tb: self-checking bench for the abundance test
// Drives n values over the input channel with random gaps and checks every
// divisor_sum / is_abundant beat against a trial-division predictor. It covers
// edge values, perfect and abundant numbers, a long output stall that backs
// up the input, and a random mix where most values are small to keep the run
// short.
// ----------------------------------------------------------------------------
module abundant_number_test_tb;
    import abn_pkg::*;

    localparam int          HALF_PERIOD    = 4;
    localparam int          RESET_CYCLES   = 11;
    localparam int          MAX_WAIT       = 16;
    localparam int          LONG_HOLD      = 300;
    localparam int          SETTLE_CYCLES  = 32;
    // n = 65535 runs longest with no beat on either channel; allow several times its run
    localparam int          WATCHDOG_LIMIT = 1000000;
    localparam int          RANDOM_BLOCKS  = 4;
    localparam int          BLOCK_ITEMS    = 18;
    localparam longint unsigned SUM_CEILING = (64'd1 << OUT_SUM_BITS) - 1;

    typedef struct {
        t_in_n    n;
        t_out_sum divisor_sum;
        logic     is_abundant;
    } t_abundance;

    logic i_clk = 1'b0;
    logic i_rst_n;

    abn_in_if  in_ch ();
    abn_out_if out_ch ();

    abundant_number_test uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_abundance expected_results[$];
    int         error_count   = 0;
    int         quiet_cycles  = 0;
    bit         sender_gaps_on    = 1'b1;
    bit         receiver_stalls_on = 1'b1;
    bit         hold_output_request = 1'b0;

    // Clock
    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Sum of proper divisors by trial division, clamped to the output width
    function automatic t_abundance predict_abundance(input t_in_n raw);
        longint unsigned value;
        longint unsigned total;
        longint unsigned half;
        longint unsigned d;
        t_abundance      r;
        value = 64'(raw) & ((64'd1 << VALUE_BITS) - 1);
        total = 0;
        half  = value / 2;
        for (d = 1; d <= half; d++) begin
            if (value % d == 0) begin
                total += d;
            end
        end
        r.n           = raw;
        r.divisor_sum = (total > SUM_CEILING) ? '1 : t_out_sum'(total);
        r.is_abundant = (value != 0) && (total > value);
        return r;
    endfunction

    // Result check, then record of the input beat taken at this edge
    always @(posedge i_clk) begin
        t_abundance want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with none expected: divisor_sum %0d is_abundant %0d",
                           out_ch.divisor_sum, out_ch.is_abundant);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.divisor_sum !== want.divisor_sum) begin
                        $error("divisor_sum (n=%0d): expected %0d, actual %0d",
                               want.n, want.divisor_sum, out_ch.divisor_sum);
                        error_count++;
                    end
                    if (out_ch.is_abundant !== want.is_abundant) begin
                        $error("is_abundant (n=%0d): expected %0d, actual %0d",
                               want.n, want.is_abundant, out_ch.is_abundant);
                        error_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_results = {expected_results, predict_abundance(in_ch.n)};
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[abundant_number_test] ERROR");
                $finish;
            end
        end
    end

    // Output side: random stall per beat, plus one long hold on request
    initial begin : result_receiver
        int unsigned stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_output_request) begin
                hold_output_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = receiver_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Offer one n; returns at the edge where the beat is taken, valid still high
    task automatic send_value(input t_in_n value);
        int unsigned gap;
        gap = sender_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.n     <= value;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Mostly small n for speed, some multiples of 12, rarely the full range
    function automatic t_in_n random_value();
        int unsigned sel;
        sel = $urandom_range(0, 31);
        if (sel == 0) begin
            return t_in_n'($urandom_range(0, 65535));
        end else if (sel <= 10) begin
            return t_in_n'(12 * $urandom_range(0, 85));
        end else if (sel <= 13) begin
            return t_in_n'($urandom_range(0, 15));
        end
        return t_in_n'($urandom_range(0, 1023));
    endfunction

    // Zero, one, primes, perfect numbers, first even and odd abundant numbers
    task automatic test_small_values();
        t_in_n values[$];
        values = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd12, 16'd18,
                   16'd20, 16'd28, 16'd97, 16'd496, 16'd945};
        foreach (values[k]) begin
            send_value(values[k]);
        end
        wait_results_drained();
    endtask

    // Extremes of the 16-bit field: all ones, top bit alone, big prime, big sum
    task automatic test_field_extremes();
        t_in_n values[$];
        values = '{16'hFFFF, 16'h8000, 16'd65521, 16'd55440};
        foreach (values[k]) begin
            send_value(values[k]);
        end
        wait_results_drained();
    endtask

    // Long output stall while the sender keeps offering, so the input backs up
    task automatic test_output_backpressure();
        sender_gaps_on     = 1'b0;
        hold_output_request = 1'b1;
        repeat (10) begin
            send_value(t_in_n'($urandom_range(0, 63)));
        end
        // sender pauses until everything has drained
        wait_results_drained();
        sender_gaps_on = 1'b1;
    endtask

    // Random values in blocks, each with its own mix of idling on both sides
    task automatic test_random_values();
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            sender_gaps_on     = b[0];
            receiver_stalls_on = b[1];
            repeat (BLOCK_ITEMS) begin
                send_value(random_value());
            end
            if (b == 1) begin
                wait_results_drained();
            end
        end
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        wait_results_drained();
    endtask

    // Main sequence
    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.n     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_values();
        test_field_extremes();
        test_output_backpressure();
        test_random_values();

        // catch any stray beat after the last expected one
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[abundant_number_test] OK");
        end else begin
            $display("[abundant_number_test] ERROR");
        end
        $finish;
    end

endmodule
